[hw/rtl/olie_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olie_pkg: shared definitions for the ordered list engine
// Widths, operation and status codes, sequencer states and the structs that
// pass between the control unit, the list memory and the top level.
// ----------------------------------------------------------------------------
package olie_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 7;

  // Width in which a request position and the entry count are compared.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_GET    = 3'd1,
    OP_UPDATE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_REMOVE = 3'd4
  } olie_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } olie_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_GET_RD,
    S_GET_WAIT,
    S_UPD_WR,
    S_SCAN,
    S_REM_RD,
    S_REM_WR,
    S_DONE
  } olie_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] item_value;
  } olie_cmd_t;

  typedef struct packed {
    olie_status_t      status;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [LEN_W-1:0]  list_length;
  } olie_res_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } olie_mem_req_t;

endpackage

[hw/rtl/olie_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olie_cmd_if: request channel of the ordered list engine
// Valid/ready channel carrying one operation per beat.
// ----------------------------------------------------------------------------
interface olie_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [olie_pkg::OP_W-1:0]           op;
  logic [olie_pkg::POS_W-1:0]          position;
  logic signed [olie_pkg::DATA_W-1:0]  item_value;

  modport source (output valid, output op, output position, output item_value,
                  input ready);
  modport sink   (input valid, input op, input position, input item_value,
                  output ready);
endinterface

[hw/rtl/olie_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olie_rsp_if: response channel of the ordered list engine
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface olie_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [olie_pkg::STAT_W-1:0]         status;
  logic signed [olie_pkg::DATA_W-1:0]  read_value;
  logic [olie_pkg::POS_W-1:0]          found_position;
  logic [olie_pkg::LEN_W-1:0]          list_length;

  modport source (output valid, output status, output read_value,
                  output found_position, output list_length, input ready);
  modport sink   (input valid, input status, input read_value,
                  input found_position, input list_length, output ready);
endinterface

[hw/rtl/olie_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olie_ram: single-port RAM with registered read data
// One read or one write per cycle; read data appears the cycle after.
// ----------------------------------------------------------------------------
module olie_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[hw/rtl/olie_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olie_ctrl: sequencer and compare unit of the ordered list engine
// Walks the list memory one access per cycle to shift, read, write and
// search entries, and keeps the entry count.
// ----------------------------------------------------------------------------
module olie_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  olie_pkg::olie_cmd_t     cmd,
  output logic                    res_valid,
  input  logic                    res_ready,
  output olie_pkg::olie_res_t     res,
  output olie_pkg::olie_mem_req_t mem_req,
  input  logic [olie_pkg::DATA_W-1:0] mem_rdata
);

  localparam int CNT_W = olie_pkg::CNT_W;
  localparam int CMP_W = olie_pkg::CMP_W;
  localparam int ADDR_W = olie_pkg::ADDR_W;

  olie_pkg::olie_state_t state, state_next;

  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            idx;
  logic [CNT_W-1:0]            at;
  logic [CNT_W-1:0]            hit_idx;
  logic [CNT_W-1:0]            pend_idx;
  logic                        hit;
  logic                        pend;
  logic [olie_pkg::OP_W-1:0]   op;
  logic [olie_pkg::DATA_W-1:0] val;
  olie_pkg::olie_status_t      status;
  logic [olie_pkg::DATA_W-1:0] rd;
  logic [CNT_W-1:0]            fpos;

  logic [CMP_W-1:0] pos_cmp;
  logic [CMP_W-1:0] count_cmp;
  logic             pos_in_range;
  logic             is_full;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic             scan_more;
  logic             scan_end;
  logic             match;

  assign pos_cmp      = CMP_W'(cmd.position);
  assign count_cmp    = CMP_W'(count);
  assign pos_in_range = pos_cmp < count_cmp;
  assign is_full      = count >= CNT_W'(olie_pkg::CAPACITY);
  assign idx_inc      = idx + CNT_W'(1);
  assign idx_dec      = idx - CNT_W'(1);
  assign scan_more    = idx < count;
  assign scan_end     = !scan_more && !pend;
  assign match        = pend && (mem_rdata == val);

  assign cmd_ready = (state == olie_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      olie_pkg::S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            olie_pkg::OP_INSERT: begin
              state_next = is_full ? olie_pkg::S_DONE : olie_pkg::S_INS_RD;
            end
            olie_pkg::OP_GET: begin
              state_next = pos_in_range ? olie_pkg::S_GET_RD : olie_pkg::S_DONE;
            end
            olie_pkg::OP_UPDATE: begin
              state_next = pos_in_range ? olie_pkg::S_UPD_WR : olie_pkg::S_DONE;
            end
            olie_pkg::OP_SEARCH: begin
              state_next = olie_pkg::S_SCAN;
            end
            olie_pkg::OP_REMOVE: begin
              state_next = (count == '0) ? olie_pkg::S_DONE : olie_pkg::S_SCAN;
            end
            default: begin
              state_next = olie_pkg::S_DONE;
            end
          endcase
        end
      end
      olie_pkg::S_INS_RD: begin
        state_next = (idx == at) ? olie_pkg::S_DONE : olie_pkg::S_INS_WR;
      end
      olie_pkg::S_INS_WR:   state_next = olie_pkg::S_INS_RD;
      olie_pkg::S_GET_RD:   state_next = olie_pkg::S_GET_WAIT;
      olie_pkg::S_GET_WAIT: state_next = olie_pkg::S_DONE;
      olie_pkg::S_UPD_WR:   state_next = olie_pkg::S_DONE;
      olie_pkg::S_SCAN: begin
        if (scan_end) begin
          if (hit && (op == olie_pkg::OP_REMOVE)) begin
            state_next = olie_pkg::S_REM_RD;
          end else begin
            state_next = olie_pkg::S_DONE;
          end
        end
      end
      olie_pkg::S_REM_RD: begin
        state_next = (idx_inc < count) ? olie_pkg::S_REM_WR : olie_pkg::S_DONE;
      end
      olie_pkg::S_REM_WR:   state_next = olie_pkg::S_REM_RD;
      olie_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = olie_pkg::S_IDLE;
        end
      end
      default: state_next = olie_pkg::S_IDLE;
    endcase
  end

  // Memory access and result handshake.
  always_comb begin
    mem_req.en    = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.addr  = idx[ADDR_W-1:0];
    mem_req.wdata = mem_rdata;
    res_valid     = 1'b0;
    unique case (state)
      olie_pkg::S_INS_RD: begin
        mem_req.en = 1'b1;
        if (idx == at) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = val;
        end else begin
          mem_req.addr = idx_dec[ADDR_W-1:0];
        end
      end
      olie_pkg::S_INS_WR: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
      end
      olie_pkg::S_GET_RD: begin
        mem_req.en = 1'b1;
      end
      olie_pkg::S_UPD_WR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.wdata = val;
      end
      olie_pkg::S_SCAN: begin
        mem_req.en = scan_more;
      end
      olie_pkg::S_REM_RD: begin
        mem_req.en   = idx_inc < count;
        mem_req.addr = idx_inc[ADDR_W-1:0];
      end
      olie_pkg::S_REM_WR: begin
        mem_req.en = 1'b1;
        mem_req.we = 1'b1;
      end
      olie_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        mem_req.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= olie_pkg::S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        olie_pkg::S_IDLE: begin
          if (cmd_valid) begin
            op     <= cmd.op;
            val    <= cmd.item_value;
            status <= olie_pkg::STAT_OK;
            rd     <= '0;
            fpos   <= '0;
            pend   <= 1'b0;
            hit    <= 1'b0;
            unique case (cmd.op)
              olie_pkg::OP_INSERT: begin
                idx <= count;
                at  <= (pos_cmp > count_cmp) ? count : CNT_W'(cmd.position);
                if (is_full) begin
                  status <= olie_pkg::STAT_FULL;
                end
              end
              olie_pkg::OP_GET, olie_pkg::OP_UPDATE: begin
                idx <= CNT_W'(cmd.position);
                if (!pos_in_range) begin
                  status <= olie_pkg::STAT_RANGE;
                end
              end
              olie_pkg::OP_SEARCH: begin
                idx <= '0;
              end
              olie_pkg::OP_REMOVE: begin
                idx <= '0;
                if (count == '0) begin
                  status <= olie_pkg::STAT_EMPTY;
                end
              end
              default: begin
                idx <= '0;
              end
            endcase
          end
        end
        olie_pkg::S_INS_RD: begin
          if (idx == at) begin
            count <= count + CNT_W'(1);
            fpos  <= at;
          end
        end
        olie_pkg::S_INS_WR: begin
          idx <= idx_dec;
        end
        olie_pkg::S_GET_WAIT: begin
          rd <= mem_rdata;
        end
        olie_pkg::S_SCAN: begin
          // Reads are issued one per cycle; each compare uses the data of
          // the read issued in the cycle before.
          pend     <= scan_more;
          pend_idx <= idx;
          if (scan_more) begin
            idx <= idx_inc;
          end
          if (match) begin
            hit     <= 1'b1;
            hit_idx <= pend_idx;
          end
          if (scan_end) begin
            if (hit) begin
              fpos <= hit_idx;
              idx  <= hit_idx;
            end else begin
              status <= olie_pkg::STAT_NOTFOUND;
            end
          end
        end
        olie_pkg::S_REM_RD: begin
          if (!(idx_inc < count)) begin
            count <= count - CNT_W'(1);
          end
        end
        olie_pkg::S_REM_WR: begin
          idx <= idx_inc;
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

  assign res.status         = status;
  assign res.read_value     = rd;
  assign res.found_position = olie_pkg::POS_W'(fpos);
  assign res.list_length    = olie_pkg::LEN_W'(count);

endmodule

[hw/rtl/ordered_list_insert_remove_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_engine: ordered list of signed 32-bit values
// Insert, get, update, search-last and remove on a list held in one
// single-port memory, with one result beat per request beat.
// ----------------------------------------------------------------------------
// The engine holds up to CAPACITY (64) signed values in order. Each request
// beat carries one operation and produces exactly one response beat with a
// status, the value read by a get, a position and the list length after the
// operation. Work is done by a small sequencer over a single-port memory
// that performs one read or one write per cycle, and the engine takes no new
// request while an operation is in progress. A get reads its entry and an
// update writes it; an operation rejected by its status check or an unused
// op code goes straight to the done state, in which every operation hands
// its result over. An insert at position p into a list of n entries shifts
// n - p entries, each by a read then a write on the one port. A search reads
// all n entries in a pipelined sweep. A remove is a search followed by a
// left shift of the entries after the match, each by a read then a write.
// The response is held in an output register, so a new request may be taken
// while an earlier response waits to be taken.
// No clearing pass is needed after reset: only positions below the count are
// ever read, and all of those have been written.
module ordered_list_insert_remove_engine (
  input  logic            clk,
  input  logic            rst,
  olie_cmd_if.sink        cmd,
  olie_rsp_if.source      rsp
);

  olie_pkg::olie_cmd_t     cmd_data;
  olie_pkg::olie_res_t     res;
  olie_pkg::olie_mem_req_t mem_req;
  logic [olie_pkg::DATA_W-1:0] mem_rdata;
  logic res_valid;
  logic res_ready;

  // Response register state.
  logic                rsp_valid;
  olie_pkg::olie_res_t rsp_data;

  assign cmd_data.op         = cmd.op;
  assign cmd_data.position   = cmd.position;
  assign cmd_data.item_value = cmd.item_value;

  olie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .cmd       (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  olie_ram #(
    .DEPTH (olie_pkg::CAPACITY),
    .WIDTH (olie_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // The response register takes a new result whenever it is empty or its
  // current beat is being taken in the same cycle.
  assign res_ready = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp_data <= res;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_data.status;
  assign rsp.read_value     = rsp_data.read_value;
  assign rsp.found_position = rsp_data.found_position;
  assign rsp.list_length    = rsp_data.list_length;

endmodule
